// ===== rtl/zbuffer_pixel_plotter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the z-buffer pixel plotter
// Each macro expects clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ZBUFFER_PIXEL_PLOTTER_ASSERT_SVH
`define ZBUFFER_PIXEL_PLOTTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ZBP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ZBP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/zbp_pkg.sv =====
// ----------------------------------------------------------------------------
// zbp_pkg
// Shared types and constants of the z-buffer pixel plotter.
// ----------------------------------------------------------------------------
`default_nettype none

package zbp_pkg;

	localparam int WIDTH_PIXELS  = 512;
	localparam int HEIGHT_PIXELS = 512;
	localparam int PIX_COUNT     = WIDTH_PIXELS * HEIGHT_PIXELS;
	localparam int PIX_AW        = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
	localparam int COLOR_W       = 24;
	localparam int DEPTH_W       = 32;

	localparam logic [COLOR_W-1:0]        WHITE       = 24'hFF_FFFF;
	localparam logic signed [DEPTH_W-1:0] DEPTH_FLOOR = 32'sh8000_0000;

	localparam logic [1:0] KIND_PLOT      = 2'd0;
	localparam logic [1:0] KIND_CLR_COLOR = 2'd1;
	localparam logic [1:0] KIND_CLR_DEPTH = 2'd2;
	localparam logic [1:0] KIND_READ      = 2'd3;

	typedef struct packed {
		logic [1:0]          kind;
		logic signed [11:0]  x;
		logic signed [11:0]  y;
		logic signed [31:0]  z;
		logic [7:0]          red;
		logic [7:0]          green;
		logic [7:0]          blue;
	} item_t;

	typedef struct packed {
		logic                drawn;
		logic [7:0]          pixel_red;
		logic [7:0]          pixel_green;
		logic [7:0]          pixel_blue;
		logic signed [31:0]  pixel_depth;
	} result_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EVAL,
		ST_CLR_COLOR,
		ST_CLR_DEPTH
	} state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic sweep_color;
		logic sweep_depth;
	} zbp_cmd_t;

	typedef struct packed {
		logic sweep_last;
	} zbp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/zbp_ram.sv =====
// ----------------------------------------------------------------------------
// zbp_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module zbp_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/zbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// zbp_ctrl
// Controller: sequences the start-up clear, clears, plots and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module zbp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [1:0]       kind,
	input  wire zbp_pkg::zbp_stat_t stat,
	output zbp_pkg::zbp_cmd_t     cmd,
	output logic                  busy,
	output logic                  done
);
	import zbp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		done    = 1'b0;
		case (state_q)
			ST_INIT: begin
				// Both stores are swept together after reset; no beat is produced.
				cmd.sweep_color = 1'b1;
				cmd.sweep_depth = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (kind)
						KIND_CLR_COLOR: state_d = ST_CLR_COLOR;
						KIND_CLR_DEPTH: state_d = ST_CLR_DEPTH;
						default:        state_d = ST_EVAL;
					endcase
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				done     = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_CLR_COLOR: begin
				cmd.sweep_color = 1'b1;
				if (stat.sweep_last) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CLR_DEPTH: begin
				cmd.sweep_depth = 1'b1;
				if (stat.sweep_last) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/zbp_datapath.sv =====
// ----------------------------------------------------------------------------
// zbp_datapath
// Address mapping, colour and depth stores, depth test and result forming.
// ----------------------------------------------------------------------------
`default_nettype none

module zbp_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire zbp_pkg::item_t    item,
	input  wire zbp_pkg::zbp_cmd_t cmd,
	output zbp_pkg::zbp_stat_t     stat,
	output zbp_pkg::result_t       result
);
	import zbp_pkg::*;

	logic signed [12:0] row;
	logic               x_ok;
	logic               row_ok;
	logic               hit;
	logic [23:0]        idx_wide;
	logic [PIX_AW-1:0]  idx_in;

	item_t              item_q;
	logic [PIX_AW-1:0]  idx_q;
	logic               hit_q;
	logic [PIX_AW-1:0]  cnt_q;

	logic               sweeping;
	logic               pass;
	logic               do_draw;
	logic [PIX_AW-1:0]  waddr;
	logic [COLOR_W-1:0] color_wdata;
	logic [DEPTH_W-1:0] depth_wdata;
	logic [COLOR_W-1:0] color_rd;
	logic [DEPTH_W-1:0] depth_rd;

	// Rows are counted from the top of the screen.
	assign row    = 13'(HEIGHT_PIXELS - 1) - 13'(item.y);
	assign x_ok   = !item.x[11] && (13'(item.x) < 13'(WIDTH_PIXELS));
	assign row_ok = !row[12] && (row < 13'(HEIGHT_PIXELS));
	assign hit    = x_ok && row_ok;

	// Column-major layout: one column holds HEIGHT_PIXELS consecutive entries.
	assign idx_wide = 24'(item.x[10:0]) * 24'(HEIGHT_PIXELS) + 24'(row[11:0]);
	assign idx_in   = idx_wide[PIX_AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			idx_q  <= idx_in;
			hit_q  <= hit;
		end
	end

	assign sweeping        = cmd.sweep_color || cmd.sweep_depth;
	assign stat.sweep_last = (cnt_q == PIX_AW'(PIX_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (sweeping) begin
			cnt_q <= stat.sweep_last ? '0 : cnt_q + 1'b1;
		end
	end

	// Ties pass the depth test.
	assign pass    = ($signed(depth_rd) <= item_q.z);
	assign do_draw = cmd.eval && (item_q.kind == KIND_PLOT) && hit_q && pass;

	assign waddr       = sweeping ? cnt_q : idx_q;
	assign color_wdata = cmd.sweep_color ? WHITE : {item_q.red, item_q.green, item_q.blue};
	assign depth_wdata = cmd.sweep_depth ? DEPTH_FLOOR : item_q.z;

	zbp_ram #(
		.DATA_W (COLOR_W),
		.DEPTH  (PIX_COUNT)
	) u_color_ram (
		.clk   (clk),
		.we    (cmd.sweep_color || do_draw),
		.waddr (waddr),
		.wdata (color_wdata),
		.re    (cmd.load),
		.raddr (idx_in),
		.rdata (color_rd)
	);

	zbp_ram #(
		.DATA_W (DEPTH_W),
		.DEPTH  (PIX_COUNT)
	) u_depth_ram (
		.clk   (clk),
		.we    (cmd.sweep_depth || do_draw),
		.waddr (waddr),
		.wdata (depth_wdata),
		.re    (cmd.load),
		.raddr (idx_in),
		.rdata (depth_rd)
	);

	always_comb begin
		result       = '0;
		result.drawn = do_draw;
		if (cmd.eval && (item_q.kind == KIND_READ) && hit_q) begin
			result.pixel_red   = color_rd[23:16];
			result.pixel_green = color_rd[15:8];
			result.pixel_blue  = color_rd[7:0];
			result.pixel_depth = $signed(depth_rd);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/zbuffer_pixel_plotter.sv =====
// Plot and read: the result beat is strobed on done in the cycle after start is taken.
// A new plot or read is taken only once busy is low again; the depth RAM is read at
// load, ahead of the depth test and write-back. A clear sweeps its store one entry a
// cycle and strobes done on its last entry. After reset both stores are swept
// together with busy high and no result beat; the receiver cannot stall, so results
// are never held.
`default_nettype none

module zbuffer_pixel_plotter (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire zbp_pkg::item_t  item,
	output logic                 busy,
	output logic                 done,
	output zbp_pkg::result_t     result
);
	import zbp_pkg::*;

	zbp_cmd_t  cmd;
	zbp_stat_t stat;

	zbp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	zbp_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== rtl/zbp_checker.sv =====
// ----------------------------------------------------------------------------
// zbp_checker
// Port-level checks on the z-buffer pixel plotter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "zbuffer_pixel_plotter_assert.svh"

module zbp_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             done,
	input wire zbp_pkg::item_t   item,
	input wire zbp_pkg::result_t result
);
	import zbp_pkg::*;

	`ZBP_ASSERT_IMP(a_done_while_busy, done, busy, "result beat outside an item")
	`ZBP_ASSERT_NXT(a_plot_read_latency, start && !busy && (item.kind == KIND_PLOT || item.kind == KIND_READ), done, "plot or read gave no beat in the next cycle")
	`ZBP_ASSERT_NXT(a_single_beat, done, !done && !busy, "more than one beat for an item")
	`ZBP_ASSERT_IMP(a_drawn_no_pixel, done && result.drawn, result.pixel_depth == 0 && result.pixel_red == 0, "drawn beat carries pixel data")

endmodule

bind zbuffer_pixel_plotter zbp_checker u_zbp_checker (.*);

`default_nettype wire
